### hdl/cgrm_pkg.sv
// ----------------------------------------------------------------------------
// cgrm_pkg
// Shared op codes, field widths and the burst record passed from the gap
// accumulator to the result emitter.
// ----------------------------------------------------------------------------
package cgrm_pkg;

  localparam int CODE_W   = 4;
  localparam int IN_LEN_W = 28;
  localparam int SUM_W    = 32;

  localparam logic [CODE_W-1:0] OP_INS = 4'd1;
  localparam logic [CODE_W-1:0] OP_DEL = 4'd2;

  // One closed gap run plus the operation that closed it
  typedef struct packed {
    logic                ins_valid;
    logic [SUM_W-1:0]    ins_len;
    logic                del_valid;
    logic [SUM_W-1:0]    del_len;
    logic [CODE_W-1:0]   code;
    logic [IN_LEN_W-1:0] length;
  } burst_t;

endpackage

### hdl/cgrm_accum.sv
// ----------------------------------------------------------------------------
// cgrm_accum
// Gap run accumulator: sums insertion and deletion lengths with saturation
// and hands a burst record over when a non-gap operation closes the run.
// ----------------------------------------------------------------------------
module cgrm_accum
  import cgrm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [CODE_W-1:0]   code,
  input  logic [IN_LEN_W-1:0] length,
  output logic                burst_load,
  output burst_t              burst
);

  logic [SUM_W-1:0] ins_sum;
  logic             ins_seen;
  logic [SUM_W-1:0] del_sum;
  logic             del_seen;
  logic [SUM_W-1:0] ins_sum_next;
  logic [SUM_W-1:0] del_sum_next;
  logic             is_ins;
  logic             is_del;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [IN_LEN_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W-IN_LEN_W+1){1'b0}}, add};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  assign is_ins       = (code == OP_INS);
  assign is_del       = (code == OP_DEL);
  assign ins_sum_next = sat_add(ins_sum, length);
  assign del_sum_next = sat_add(del_sum, length);

  assign burst_load      = accept & ~is_ins & ~is_del;
  assign burst.ins_valid = ins_seen;
  assign burst.ins_len   = ins_sum;
  assign burst.del_valid = del_seen;
  assign burst.del_len   = del_sum;
  assign burst.code      = code;
  assign burst.length    = length;

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_sum  <= '0;
      ins_seen <= 1'b0;
      del_sum  <= '0;
      del_seen <= 1'b0;
    end else if (accept) begin
      if (is_ins) begin
        ins_sum  <= ins_sum_next;
        ins_seen <= 1'b1;
      end else if (is_del) begin
        del_sum  <= del_sum_next;
        del_seen <= 1'b1;
      end else begin
        // run closed: clear for the next one
        ins_sum  <= '0;
        ins_seen <= 1'b0;
        del_sum  <= '0;
        del_seen <= 1'b0;
      end
    end
  end

  // a sum only grows while its kind has been seen
  assert property (@(posedge clk) disable iff (rst) !ins_seen |-> ins_sum == '0)
    else $error("insertion sum non-zero with no insertion seen");
  assert property (@(posedge clk) disable iff (rst) !del_seen |-> del_sum == '0)
    else $error("deletion sum non-zero with no deletion seen");
  assert property (@(posedge clk) disable iff (rst) burst_load |=> !ins_seen && !del_seen)
    else $error("gap state not cleared after run closed");

endmodule

### hdl/cgrm_emit.sv
// ----------------------------------------------------------------------------
// cgrm_emit
// Result emitter: holds one burst and drains it, merged insertion first,
// then merged deletion, then the closing operation, into the output register.
// ----------------------------------------------------------------------------
module cgrm_emit
  import cgrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              burst_load,
  input  burst_t            burst,
  output logic              burst_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_code,
  output logic [SUM_W-1:0]  out_length,
  output logic              out_last
);

  logic   pend_ins;
  logic   pend_del;
  logic   pend_op;
  burst_t held;
  logic   out_load;
  logic   have;

  assign out_load   = ~out_valid | out_ready;
  assign have       = pend_ins | pend_del | pend_op;
  assign burst_free = ~have | (out_load & pend_op & ~pend_ins & ~pend_del);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_ins  <= 1'b0;
      pend_del  <= 1'b0;
      pend_op   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= have;
      end
      // a new burst only lands once the held one is gone
      if (burst_load) begin
        pend_ins <= burst.ins_valid;
        pend_del <= burst.del_valid;
        pend_op  <= 1'b1;
      end else if (out_load) begin
        if (pend_ins) begin
          pend_ins <= 1'b0;
        end else if (pend_del) begin
          pend_del <= 1'b0;
        end else begin
          pend_op <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      held <= burst;
    end
    if (out_load && have) begin
      if (pend_ins) begin
        out_code   <= OP_INS;
        out_length <= held.ins_len;
        out_last   <= 1'b0;
      end else if (pend_del) begin
        out_code   <= OP_DEL;
        out_length <= held.del_len;
        out_last   <= 1'b0;
      end else begin
        out_code   <= held.code;
        out_length <= {{(SUM_W-IN_LEN_W){1'b0}}, held.length};
        out_last   <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) (pend_ins || pend_del) |-> pend_op)
    else $error("merged gap pending without its closing operation");
  assert property (@(posedge clk) disable iff (rst) burst_load |-> burst_free)
    else $error("burst loaded over an undrained one");
  assert property (@(posedge clk) disable iff (rst) burst_load |=> pend_op)
    else $error("closing operation lost on burst load");
  assert property (@(posedge clk) disable iff (rst) (out_load && !have) |=> !out_valid)
    else $error("result shown with nothing pending");

endmodule

### hdl/cigar_gap_run_merger_unit.sv
// ----------------------------------------------------------------------------
// cigar_gap_run_merger_unit
// Merges runs of CIGAR insertions and deletions into one I and one D.
// ----------------------------------------------------------------------------
// Input stream: one CIGAR operation per transfer, op code on s_axis_tuser and
// length on s_axis_tdata. I and D operations are summed (saturating at 32
// bits) and produce nothing. Any other operation releases the merged I (if
// any), then the merged D (if any), then itself; the last of these carries
// m_axis_tlast. Output: code on m_axis_tuser, length on m_axis_tdata.
// m_axis_tvalid rises once the closing operation is taken and has passed
// through the held burst register and then the output register.
// Throughput: one result per cycle on the output while the receiver is ready,
// so an operation that releases merged gaps holds the input while they drain;
// gap operations and plain operations stream at one per cycle while no burst
// is draining and the receiver is ready. The single output port sets that rate.
// s_axis_tready drops while a burst is still draining beyond its last result.
// A stalled receiver holds the output register; input stalls once the held
// burst cannot move. Reset clears the gap sums and empties both registers. A
// gap run with no following operation stays pending until reset.
// ----------------------------------------------------------------------------
module cigar_gap_run_merger_unit
  import cgrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [27:0] op_length, [31:28] zero
  input  logic [3:0]  s_axis_tuser,   // [3:0] op_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] out_length
  output logic [3:0]  m_axis_tuser,   // [3:0] out_code
  output logic        m_axis_tlast    // run_last
);

  logic   accept;
  logic   burst_load;
  logic   burst_free;
  burst_t burst;

  assign s_axis_tready = burst_free;
  assign accept        = s_axis_tvalid & s_axis_tready;

  cgrm_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .code       (s_axis_tuser),
    .length     (s_axis_tdata[IN_LEN_W-1:0]),
    .burst_load (burst_load),
    .burst      (burst)
  );

  cgrm_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .burst_load (burst_load),
    .burst      (burst),
    .burst_free (burst_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_code   (m_axis_tuser),
    .out_length (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

### tb/sv/cigar_gap_run_merger_unit_tb.sv
// ----------------------------------------------------------------------------
// cigar_gap_run_merger_unit_tb
// Streams CIGAR operations into the gap run merger and checks every result
// against an in-bench model of the I/D run merging, with saturating sums, a
// pending run left at the end, random idling on both sides and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module cigar_gap_run_merger_unit_tb;
  import cgrm_pkg::*;

  localparam logic [CODE_W-1:0] OP_MATCH    = 4'd0;
  localparam logic [CODE_W-1:0] OP_SKIP     = 4'd3;
  localparam logic [CODE_W-1:0] OP_SOFT     = 4'd4;
  localparam logic [CODE_W-1:0] OP_HARD     = 4'd5;
  localparam logic [CODE_W-1:0] OP_PAD      = 4'd6;
  localparam logic [CODE_W-1:0] OP_SEQ_EQ   = 4'd7;
  localparam logic [CODE_W-1:0] OP_SEQ_DIFF = 4'd8;
  localparam logic [CODE_W-1:0] OP_ODD_LO   = 4'd9;
  localparam logic [CODE_W-1:0] OP_ODD_HI   = 4'd15;

  localparam logic [IN_LEN_W-1:0] LEN_MAX = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX = '1;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [IN_LEN_W-1:0] len;
  } cigar_op_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SUM_W-1:0]  len;
    logic              last;
  } cigar_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [27:0] op_length, [31:28] zero
  logic [3:0]  s_axis_tuser = '0;   // [3:0] op_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] out_length
  logic [3:0]  m_axis_tuser;        // [3:0] out_code
  logic        m_axis_tlast;

  cigar_op_t  pending_ops[$];
  cigar_out_t merged_due[$];

  int errors = 0;
  int ops_queued = 0;
  int ops_taken = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_kick = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;

  // gap run state of the model
  logic [SUM_W-1:0] ins_total = '0;
  logic             ins_open = 1'b0;
  logic [SUM_W-1:0] del_total = '0;
  logic             del_open = 1'b0;

  cigar_gap_run_merger_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc,
                                                   logic [IN_LEN_W-1:0] len);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W-IN_LEN_W+1){1'b0}}, len};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  task automatic predict_merge(cigar_op_t op);
    if (op.code == OP_INS) begin
      ins_total = add_clamped(ins_total, op.len);
      ins_open  = 1'b1;
    end else if (op.code == OP_DEL) begin
      del_total = add_clamped(del_total, op.len);
      del_open  = 1'b1;
    end else begin
      if (ins_open)
        merged_due.insert(merged_due.size(), cigar_out_t'{OP_INS, ins_total, 1'b0});
      if (del_open)
        merged_due.insert(merged_due.size(), cigar_out_t'{OP_DEL, del_total, 1'b0});
      merged_due.insert(merged_due.size(), cigar_out_t'{op.code, SUM_W'(op.len), 1'b1});
      ins_total = '0;
      ins_open  = 1'b0;
      del_total = '0;
      del_open  = 1'b0;
    end
  endtask

  // Sender: hold an offered transfer until taken, idle only between items
  always @(negedge clk) begin
    cigar_op_t op;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(32 - IN_LEN_W){1'b0}}, op.len};
        s_axis_tuser  <= op.code;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each input transfer, then check each output transfer
  always @(posedge clk) begin
    cigar_out_t want;
    in_taken = s_axis_tvalid && s_axis_tready;
    if (!rst && in_taken) begin
      predict_merge('{s_axis_tuser, s_axis_tdata[IN_LEN_W-1:0]});
      ops_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (merged_due.size() == 0) begin
        $error("result with none expected: out_code %0d out_length %0d run_last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = merged_due.pop_front();
        if (m_axis_tuser !== want.code) begin
          $error("out_code: expected %0d, got %0d", want.code, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== want.len) begin
          $error("out_length: expected %0d, got %0d", want.len, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_op(logic [CODE_W-1:0] code, logic [IN_LEN_W-1:0] len);
    pending_ops.insert(pending_ops.size(), cigar_op_t'{code, len});
    ops_queued++;
  endtask

  function automatic logic [IN_LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_MAX;
      2, 3, 4: return IN_LEN_W'($urandom_range(1, 100));
      default: return IN_LEN_W'($urandom());
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_gap_code();
    return $urandom_range(0, 1) ? OP_INS : OP_DEL;
  endfunction

  function automatic logic [CODE_W-1:0] pick_plain_code();
    logic [CODE_W-1:0] c;
    do c = CODE_W'($urandom_range(0, 15));
    while (c == OP_INS || c == OP_DEL);
    return c;
  endfunction

  // Mostly gap runs closed by a plain op; now and then a saturating run or
  // a lone op of any code
  task automatic queue_random_runs(int target);
    int count;
    int n;
    logic [CODE_W-1:0] gap;
    count = 0;
    while (count < target) begin
      case ($urandom_range(0, 19))
        0: begin
          gap = pick_gap_code();
          n = $urandom_range(17, 20);
          repeat (n) queue_op(gap, LEN_MAX);
          if ($urandom_range(0, 1)) begin
            queue_op(gap == OP_INS ? OP_DEL : OP_INS, pick_length());
            n++;
          end
          queue_op(pick_plain_code(), pick_length());
          count += n + 1;
        end
        1: begin
          queue_op(CODE_W'($urandom_range(0, 15)), pick_length());
          count++;
        end
        default: begin
          n = $urandom_range(0, 4);
          repeat (n) queue_op(pick_gap_code(), pick_length());
          queue_op(pick_plain_code(), pick_length());
          count += n + 1;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (ops_taken != ops_queued || merged_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 35;

    queue_op(OP_MATCH, '0);
    queue_op(OP_MATCH, LEN_MAX);
    queue_op(OP_INS, 28'd5);
    queue_op(OP_MATCH, 28'd10);
    queue_op(OP_DEL, 28'd7);
    queue_op(OP_SKIP, 28'd3);
    queue_op(OP_INS, 28'd1);
    queue_op(OP_DEL, 28'd2);
    queue_op(OP_INS, 28'd3);
    queue_op(OP_DEL, LEN_MAX);
    queue_op(OP_SOFT, 28'd9);
    // zero-length gaps still count as seen
    queue_op(OP_INS, '0);
    queue_op(OP_HARD, '0);
    queue_op(OP_DEL, '0);
    queue_op(OP_PAD, 28'd1);
    queue_op(OP_SEQ_EQ, LEN_MAX);
    queue_op(OP_SEQ_DIFF, 28'd42);
    // codes outside the BAM set pass through and close the run
    queue_op(OP_INS, 28'd11);
    queue_op(OP_ODD_LO, 28'd4);
    queue_op(OP_DEL, 28'd12);
    queue_op(OP_ODD_HI, 28'hA5A5A5A);
    wait_drained();

    // fill the block against a stalled receiver
    queue_random_runs(100);
    hold_kick++;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_runs(100);
    // leave a gap run open at the end: it must never come out
    queue_op(OP_INS, pick_length());
    queue_op(OP_DEL, pick_length());
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/cgrm_pkg.sv
hdl/cgrm_accum.sv
hdl/cgrm_emit.sv
hdl/cigar_gap_run_merger_unit.sv
tb/sv/cigar_gap_run_merger_unit_tb.sv
